// ===== src/clms_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// clms_pkg
// Types, operation codes and the fixed LED-to-pin wiring table of the
// charlieplexed LED matrix scanner.
// ----------------------------------------------------------------------------
package clms_pkg;

  localparam int unsigned MatrixRows    = 9;
  localparam int unsigned MatrixColumns = 14;
  localparam int unsigned PinCount      = 12;

  localparam int unsigned RowIdxW  = 4;
  localparam int unsigned LineW    = 4;

  localparam logic [1:0] OP_STAGE   = 2'd0;
  localparam logic [1:0] OP_PRESENT = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;

  typedef logic [MatrixColumns-1:0]             row_t;
  typedef logic [PinCount-1:0]                  pins_t;
  typedef row_t  [MatrixRows-1:0]               frame_t;
  typedef pins_t [PinCount-1:0]                 drive_mat_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [RowIdxW-1:0] row_index;
    row_t               row_bits;
  } in_beat_t;

  typedef struct packed {
    pins_t            pin_drive;
    pins_t            pin_high;
    logic [LineW-1:0] line_number;
  } out_beat_t;

  // One LED: the pin that goes high and the pin that goes low to light it.
  typedef struct packed {
    logic [3:0] hi;
    logic [3:0] lo;
  } led_pins_t;

  typedef led_pins_t [0:MatrixColumns-1] led_row_t;

  // Indexed [row][13-column]; column 0 is the leftmost LED.
  localparam led_row_t LED_MAP [MatrixRows] = '{
    '{'{4'd0,4'd11}, '{4'd11,4'd0}, '{4'd1,4'd11}, '{4'd11,4'd1}, '{4'd2,4'd11},
      '{4'd11,4'd2}, '{4'd11,4'd10}, '{4'd11,4'd9}, '{4'd11,4'd8}, '{4'd11,4'd7},
      '{4'd11,4'd6}, '{4'd11,4'd5}, '{4'd11,4'd4}, '{4'd11,4'd3}},
    '{'{4'd0,4'd10}, '{4'd10,4'd0}, '{4'd1,4'd10}, '{4'd10,4'd1}, '{4'd2,4'd10},
      '{4'd10,4'd2}, '{4'd10,4'd11}, '{4'd10,4'd9}, '{4'd10,4'd8}, '{4'd10,4'd7},
      '{4'd10,4'd6}, '{4'd10,4'd5}, '{4'd10,4'd4}, '{4'd10,4'd3}},
    '{'{4'd0,4'd9}, '{4'd9,4'd0}, '{4'd1,4'd9}, '{4'd9,4'd1}, '{4'd2,4'd9},
      '{4'd9,4'd2}, '{4'd9,4'd11}, '{4'd9,4'd10}, '{4'd9,4'd8}, '{4'd9,4'd7},
      '{4'd9,4'd6}, '{4'd9,4'd5}, '{4'd9,4'd4}, '{4'd9,4'd3}},
    '{'{4'd0,4'd8}, '{4'd8,4'd0}, '{4'd1,4'd8}, '{4'd8,4'd1}, '{4'd2,4'd8},
      '{4'd8,4'd2}, '{4'd8,4'd11}, '{4'd8,4'd10}, '{4'd8,4'd9}, '{4'd8,4'd7},
      '{4'd8,4'd6}, '{4'd8,4'd5}, '{4'd8,4'd4}, '{4'd8,4'd3}},
    '{'{4'd0,4'd7}, '{4'd7,4'd0}, '{4'd1,4'd7}, '{4'd7,4'd1}, '{4'd2,4'd7},
      '{4'd7,4'd2}, '{4'd7,4'd11}, '{4'd7,4'd10}, '{4'd7,4'd9}, '{4'd7,4'd8},
      '{4'd7,4'd6}, '{4'd7,4'd5}, '{4'd7,4'd4}, '{4'd7,4'd3}},
    '{'{4'd0,4'd6}, '{4'd6,4'd0}, '{4'd1,4'd6}, '{4'd6,4'd1}, '{4'd2,4'd6},
      '{4'd6,4'd2}, '{4'd6,4'd11}, '{4'd6,4'd10}, '{4'd6,4'd9}, '{4'd6,4'd8},
      '{4'd6,4'd7}, '{4'd6,4'd5}, '{4'd6,4'd4}, '{4'd6,4'd3}},
    '{'{4'd0,4'd5}, '{4'd5,4'd0}, '{4'd1,4'd5}, '{4'd5,4'd1}, '{4'd2,4'd5},
      '{4'd5,4'd2}, '{4'd5,4'd11}, '{4'd5,4'd10}, '{4'd5,4'd9}, '{4'd5,4'd8},
      '{4'd5,4'd7}, '{4'd5,4'd6}, '{4'd5,4'd4}, '{4'd5,4'd3}},
    '{'{4'd0,4'd4}, '{4'd4,4'd0}, '{4'd1,4'd4}, '{4'd4,4'd1}, '{4'd2,4'd4},
      '{4'd4,4'd2}, '{4'd4,4'd11}, '{4'd4,4'd10}, '{4'd4,4'd9}, '{4'd4,4'd8},
      '{4'd4,4'd7}, '{4'd4,4'd6}, '{4'd4,4'd5}, '{4'd4,4'd3}},
    '{'{4'd0,4'd3}, '{4'd3,4'd0}, '{4'd1,4'd3}, '{4'd3,4'd1}, '{4'd2,4'd3},
      '{4'd3,4'd2}, '{4'd3,4'd11}, '{4'd3,4'd10}, '{4'd3,4'd9}, '{4'd3,4'd8},
      '{4'd3,4'd7}, '{4'd3,4'd6}, '{4'd3,4'd5}, '{4'd3,4'd4}}
  };

  // Packed element [c] of a led_row_t is column MatrixColumns-1-c, which lines
  // up with row bit c (bit 13 is column 0). The table above is written from
  // column 13 down to column 0 for that reason.
  function automatic drive_mat_t map_frame(frame_t rows);
    drive_mat_t dm;
    led_pins_t  p;
    dm = '0;
    for (int r = 0; r < MatrixRows; r++) begin
      for (int b = 0; b < MatrixColumns; b++) begin
        p = LED_MAP[r][b];
        if (rows[r][b]) begin
          dm[p.hi][p.lo] = 1'b1;
        end
      end
    end
    return dm;
  endfunction

endpackage
`default_nettype wire

// ===== src/charlieplex_led_matrix_scanner_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// charlieplex_led_matrix_scanner_core
// Stages a 9x14 LED frame, maps it onto a 12-pin charlieplexed drive matrix
// and gives the tristate pin states for each scan tick.
// ----------------------------------------------------------------------------
// Path: a tick beat passes through the input register, then the result
// register, before it shows on the output.
// Throughput: one beat per cycle while the result side does not stall; the result register is the only stall point.
// Reset: frame, drive matrix, scan line and scan enable all clear to zero.
// ----------------------------------------------------------------------------
module charlieplex_led_matrix_scanner_core import clms_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_beat_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_beat_t      out_data_o,
  input  wire logic      cfg_we_i,
  input  wire logic      cfg_wdata_i
);

  logic             in_valid_q;
  in_beat_t         in_q;
  logic             out_valid_q;
  out_beat_t        out_q;
  out_beat_t        out_d;
  logic             scan_en_q;
  frame_t           rows_q;
  drive_mat_t       dm_q;
  logic [LineW-1:0] line_q;
  logic [LineW-1:0] line_d;

  logic is_tick;
  logic out_free;
  logic exec;
  logic in_take;
  pins_t own;

  assign is_tick  = (in_q.operation == OP_TICK);
  assign out_free = !out_valid_q || !out_stall_i;
  // Only a tick needs room in the result register; other beats retire freely.
  assign exec     = in_valid_q && (!is_tick || out_free);
  assign in_stall_o = in_valid_q && !exec;
  assign in_take  = in_valid_i && !in_stall_o;

  assign own = pins_t'(1) << line_q;

  always_comb begin
    out_d  = '0;
    line_d = line_q;
    out_d.line_number = line_q;
    if (scan_en_q) begin
      out_d.pin_high  = own;
      out_d.pin_drive = own | (dm_q[line_q] & ~own);
      line_d = (line_q == LineW'(PinCount - 1)) ? '0 : line_q + LineW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      scan_en_q   <= 1'b0;
      rows_q      <= '0;
      dm_q        <= '0;
      line_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        scan_en_q <= cfg_wdata_i;
      end
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (exec) begin
        in_valid_q <= 1'b0;
      end
      if (exec && is_tick) begin
        out_valid_q <= 1'b1;
        line_q      <= line_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (exec) begin
        case (in_q.operation)
          OP_STAGE: begin
            if (in_q.row_index < RowIdxW'(MatrixRows)) begin
              rows_q[in_q.row_index] <= in_q.row_bits;
            end
          end
          OP_PRESENT: dm_q <= map_frame(rows_q);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (exec && is_tick) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// ===== sim/tb_charlieplex_led_matrix_scanner_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_charlieplex_led_matrix_scanner_core
// Self-checking bench for the charlieplexed LED matrix scanner. Row writes,
// frame presents and scan ticks are driven through the valid/stall input and
// every tick result is compared field by field with a cycle-free prediction of
// the pin states. Both sides idle in random bursts, the receiver holds off once
// for a long stretch, and scanning is switched on and off between phases.
// ----------------------------------------------------------------------------
module tb_charlieplex_led_matrix_scanner_core;
  import clms_pkg::*;

  localparam logic [1:0]  OP_NONE     = 2'd3;
  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned LongHold    = 300;
  localparam int unsigned PhaseBeats  = 170;

  // Expected pin states of the scan ticks, with the scanner state behind them.
  class pin_scan_board;
    row_t             staged [MatrixRows];
    pins_t            drive [PinCount];
    logic [LineW-1:0] line;
    bit               enable;
    out_beat_t        pending_pins [$];
    int unsigned      errors, matched, stages, presents, ticks_on, ticks_off, ignored;

    function new();
      foreach (staged[i]) staged[i] = '0;
      foreach (drive[i]) drive[i] = '0;
      line = '0;
      enable = 1'b0;
    endfunction

    // Row r uses pin 11-r as its own pin. Columns 0..7 pair it (high) with the
    // pins 3..11 other than itself; columns 8..13 alternate direction with
    // pins 2, 1 and 0.
    function void led_wiring(int r, int c, output int hi, output int lo);
      int own;
      int other;
      own = PinCount - 1 - r;
      if (c < 8) begin
        hi = own;
        lo = (3 + c >= own) ? 4 + c : 3 + c;
      end else begin
        other = 2 - (c - 8) / 2;
        hi = (c % 2 == 0) ? own : other;
        lo = (c % 2 == 0) ? other : own;
      end
    endfunction

    function void map_lit_leds();
      int hi;
      int lo;
      foreach (drive[i]) drive[i] = '0;
      for (int r = 0; r < MatrixRows; r++) begin
        for (int c = 0; c < MatrixColumns; c++) begin
          if (staged[r][MatrixColumns-1-c]) begin
            led_wiring(r, c, hi, lo);
            drive[hi][lo] = 1'b1;
          end
        end
      end
    endfunction

    function out_beat_t predict_pins();
      out_beat_t res;
      pins_t     own;
      res.line_number = line;
      if (enable) begin
        own = pins_t'(1) << line;
        res.pin_high  = own;
        res.pin_drive = own | (drive[line] & ~own);
        line = (line == PinCount - 1) ? '0 : line + 1'b1;
        ticks_on++;
      end else begin
        res.pin_high  = '0;
        res.pin_drive = '0;
        ticks_off++;
      end
      return res;
    endfunction

    function void note_beat(in_beat_t b);
      case (b.operation)
        OP_STAGE: begin
          if (b.row_index < MatrixRows) begin
            staged[b.row_index] = b.row_bits;
            stages++;
          end else begin
            ignored++;
          end
        end
        OP_PRESENT: begin
          map_lit_leds();
          presents++;
        end
        OP_TICK: pending_pins.push_back(predict_pins());
        default: ignored++;
      endcase
    endfunction

    function int unsigned useful();
      return stages + presents + ticks_on + ticks_off;
    endfunction

    function void check_pins(out_beat_t got);
      out_beat_t want;
      if (pending_pins.size() == 0) begin
        errors++;
        $display("%0t: unexpected result drive=%h high=%h line=%0d", $time,
                 got.pin_drive, got.pin_high, got.line_number);
        return;
      end
      want = pending_pins.pop_front();
      if (got.pin_drive !== want.pin_drive) begin
        errors++;
        $display("%0t: pin_drive expected %h actual %h", $time, want.pin_drive,
                 got.pin_drive);
      end
      if (got.pin_high !== want.pin_high) begin
        errors++;
        $display("%0t: pin_high expected %h actual %h", $time, want.pin_high,
                 got.pin_high);
      end
      if (got.line_number !== want.line_number) begin
        errors++;
        $display("%0t: line_number expected %0d actual %0d", $time,
                 want.line_number, got.line_number);
      end
      matched++;
    endfunction
  endclass

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_beat_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_beat_t out_data_o;
  logic      cfg_we_i    = 1'b0;
  logic      cfg_wdata_i = 1'b0;

  pin_scan_board board;
  int unsigned   gap_odds = 4;
  bit            long_hold_req = 1'b0;
  int unsigned   cycles = 0;
  int unsigned   enable_writes = 0;

  charlieplex_led_matrix_scanner_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout, %0d results still expected", $time,
               board.pending_pins.size());
      $display("tb_charlieplex_led_matrix_scanner_core NOT OK");
      $finish;
    end
  end

  // Result side: checks every accepted beat and stalls in random bursts.
  initial begin : receiver
    int unsigned stall_left;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) board.check_pins(out_data_o);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = LongHold;
      end else if (stall_left == 0 && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
        stall_left = $urandom_range(1, 17);
      end
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_beat(input in_beat_t b);
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    board.note_beat(b);
  endtask

  task automatic send_op(input logic [1:0] op, input logic [3:0] idx, input row_t bits);
    in_beat_t b;
    b.operation = op;
    b.row_index = idx;
    b.row_bits  = bits;
    send_beat(b);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  // The register is only written with nothing in flight.
  task automatic set_scan(input bit v);
    in_valid_i <= 1'b0;
    while (board.pending_pins.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.enable = v;
    enable_writes++;
  endtask

  function automatic row_t random_row();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return row_t'($urandom);
    endcase
  endfunction

  // One frame update: rows, a present, then a run of ticks. Now and then a
  // stray beat slips in or the present is left out.
  task automatic run_frame();
    int unsigned n_rows;
    int unsigned n_ticks;
    n_rows  = $urandom_range(1, MatrixRows);
    n_ticks = $urandom_range(1, 30);
    repeat (n_rows) begin
      if ($urandom_range(0, 7) == 0) begin
        if ($urandom_range(0, 1) == 1)
          send_op(OP_STAGE, 4'($urandom_range(MatrixRows, 15)), random_row());
        else
          send_op(OP_NONE, 4'($urandom), row_t'($urandom));
      end
      send_op(OP_STAGE, 4'($urandom_range(0, MatrixRows - 1)), random_row());
    end
    if ($urandom_range(0, 7) != 0) send_op(OP_PRESENT, 4'($urandom), row_t'($urandom));
    repeat (n_ticks) send_op(OP_TICK, 4'($urandom), row_t'($urandom));
  endtask

  initial begin : stimulus
    int unsigned target;
    board = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Out of reset scanning is off: pins float on line 0.
    send_op(OP_TICK, 4'd0, '0);
    send_op(OP_STAGE, 4'd0, '1);
    send_op(OP_STAGE, 4'd8, 14'h2001);
    send_op(OP_STAGE, 4'd4, 14'h1555);
    send_op(OP_STAGE, 4'd9, '1);
    send_op(OP_STAGE, 4'd15, 14'h2AAA);
    send_op(OP_NONE, 4'd2, '1);
    send_op(OP_PRESENT, 4'd0, '0);
    set_scan(1'b1);
    // Thirteen ticks walk every line and wrap back to line 0.
    repeat (13) send_op(OP_TICK, 4'($urandom), row_t'($urandom));
    // A staged row stays invisible until the next present.
    send_op(OP_STAGE, 4'd0, '0);
    send_op(OP_TICK, 4'd0, '0);
    set_scan(1'b0);
    send_op(OP_TICK, 4'd0, '0);
    set_scan(1'b1);
    send_op(OP_TICK, 4'd0, '0);

    // Back-to-back ticks against a long receiver hold-off.
    gap_odds = 0;
    long_hold_req = 1'b1;
    repeat (40) send_op(OP_TICK, 4'($urandom), row_t'($urandom));

    for (int p = 0; p < 6; p++) begin
      set_scan((p == 1 || p == 3) ? 1'b0 : 1'b1);
      if (p == 5) begin
        gap_odds = 0;
      end else begin
        case ($urandom_range(0, 2))
          0:       gap_odds = 0;
          1:       gap_odds = 3;
          default: gap_odds = 10;
        endcase
      end
      target = board.useful() + PhaseBeats;
      while (board.useful() < target) run_frame();
    end

    in_valid_i <= 1'b0;
    while (board.pending_pins.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("Ran %0d row writes, %0d presents, %0d ignored beats and %0d ticks",
             board.stages, board.presents, board.ignored,
             board.ticks_on + board.ticks_off);
    $display("(%0d scanning, %0d idle), %0d results checked, %0d enable writes",
             board.ticks_on, board.ticks_off, board.matched, enable_writes);
    if (board.errors == 0) begin
      $display("tb_charlieplex_led_matrix_scanner_core OK");
    end else begin
      $display("tb_charlieplex_led_matrix_scanner_core NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
src/clms_pkg.sv
src/charlieplex_led_matrix_scanner_core.sv
sim/tb_charlieplex_led_matrix_scanner_core.sv
